@@ rtl/core/complex_arithmetic_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, checked at every clk edge outside reset
`define CAU_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with a fixed delay in cycles
`define CAU_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

@@ rtl/core/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Item types, opcodes, stage structs and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

    localparam int FRAC_BITS_DEF    = 8;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANG_FRAC         = 16;
    localparam int ATAN_LEN         = 24;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_CONJ  = 3'd4,
        OP_MAG   = 3'd5,
        OP_ANGLE = 3'd6
    } cau_op_t;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [15:0] a_re;
        logic signed [15:0] a_im;
        logic signed [15:0] b_re;
        logic signed [15:0] b_im;
    } cau_in_t;

    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               invalid;
        logic               saturated;
    } cau_out_t;

    // operand front end results, one item per cycle
    typedef struct packed {
        logic [2:0]         op;
        logic signed [33:0] simple_re;
        logic signed [33:0] simple_im;
        logic signed [32:0] num_re;
        logic signed [32:0] num_im;
        logic [31:0]        den;
        logic [31:0]        mag_sq;
        logic signed [15:0] a_re;
        logic signed [15:0] a_im;
    } cau_front_t;

    typedef struct packed {
        logic zero_den;
        logic neg_re;
        logic neg_im;
    } cau_div_flags_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic [21:0] atan_deg(input int idx);
        logic [21:0] val;
        case (idx)
            0:       val = 22'd2949120;
            1:       val = 22'd1740967;
            2:       val = 22'd919879;
            3:       val = 22'd466945;
            4:       val = 22'd234379;
            5:       val = 22'd117304;
            6:       val = 22'd58666;
            7:       val = 22'd29335;
            8:       val = 22'd14668;
            9:       val = 22'd7334;
            10:      val = 22'd3667;
            11:      val = 22'd1833;
            12:      val = 22'd917;
            13:      val = 22'd458;
            14:      val = 22'd229;
            15:      val = 22'd115;
            16:      val = 22'd57;
            17:      val = 22'd29;
            18:      val = 22'd14;
            19:      val = 22'd7;
            20:      val = 22'd4;
            21:      val = 22'd2;
            22:      val = 22'd1;
            default: val = 22'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/cau_front.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Input register, partial products, then sums for every operation.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  cau_pkg::cau_in_t    in_item,
    output logic                out_valid,
    output cau_pkg::cau_front_t out_item
);

    localparam logic signed [33:0] MUL_HALF = (34'sd1 <<< FRAC_BITS) >>> 1;

    logic               valid1_reg, valid2_reg, valid3_reg;
    cau_pkg::cau_in_t   item1_reg, item2_reg;
    logic signed [31:0] rr_reg, ii_reg, ri_reg, ir_reg;
    logic signed [31:0] br2_reg, bi2_reg, ar2_reg, ai2_reg;
    cau_pkg::cau_front_t front_reg, front_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_valid;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        item1_reg <= in_item;
        item2_reg <= item1_reg;
        rr_reg    <= item1_reg.a_re * item1_reg.b_re;
        ii_reg    <= item1_reg.a_im * item1_reg.b_im;
        ri_reg    <= item1_reg.a_re * item1_reg.b_im;
        ir_reg    <= item1_reg.a_im * item1_reg.b_re;
        br2_reg   <= item1_reg.b_re * item1_reg.b_re;
        bi2_reg   <= item1_reg.b_im * item1_reg.b_im;
        ar2_reg   <= item1_reg.a_re * item1_reg.a_re;
        ai2_reg   <= item1_reg.a_im * item1_reg.a_im;
        front_reg <= front_next;
    end

    always_comb
    begin
        logic signed [32:0] sum_re;
        logic signed [32:0] sum_im;
        logic signed [33:0] mul_re;
        logic signed [33:0] mul_im;
        sum_re = 33'(rr_reg) - 33'(ii_reg);
        sum_im = 33'(ri_reg) + 33'(ir_reg);
        // round half up
        mul_re = (34'(sum_re) + MUL_HALF) >>> FRAC_BITS;
        mul_im = (34'(sum_im) + MUL_HALF) >>> FRAC_BITS;

        front_next.op        = item2_reg.op;
        front_next.num_re    = 33'(rr_reg) + 33'(ii_reg);
        front_next.num_im    = 33'(ir_reg) - 33'(ri_reg);
        front_next.den       = $unsigned(br2_reg) + $unsigned(bi2_reg);
        front_next.mag_sq    = $unsigned(ar2_reg) + $unsigned(ai2_reg);
        front_next.a_re      = item2_reg.a_re;
        front_next.a_im      = item2_reg.a_im;
        front_next.simple_re = '0;
        front_next.simple_im = '0;
        case (item2_reg.op)
            cau_pkg::OP_ADD:
            begin
                front_next.simple_re = 34'(item2_reg.a_re) + 34'(item2_reg.b_re);
                front_next.simple_im = 34'(item2_reg.a_im) + 34'(item2_reg.b_im);
            end
            cau_pkg::OP_SUB:
            begin
                front_next.simple_re = 34'(item2_reg.a_re) - 34'(item2_reg.b_re);
                front_next.simple_im = 34'(item2_reg.a_im) - 34'(item2_reg.b_im);
            end
            cau_pkg::OP_MUL:
            begin
                front_next.simple_re = mul_re;
                front_next.simple_im = mul_im;
            end
            cau_pkg::OP_CONJ:
            begin
                front_next.simple_re = 34'(item2_reg.a_re);
                front_next.simple_im = -34'(item2_reg.a_im);
            end
            default:
            begin
                front_next.simple_re = '0;
                front_next.simple_im = '0;
            end
        endcase
    end

    assign out_valid = valid3_reg;
    assign out_item  = front_reg;

endmodule

`default_nettype wire

@@ rtl/core/cau_div.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider
// Two-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
    localparam int NW       = 34 + FRAC_BITS
) (
    input  logic                    clk,
    input  logic signed [32:0]      num_re,
    input  logic signed [32:0]      num_im,
    input  logic [31:0]             den,
    output logic [NW-1:0]           q_re,
    output logic [NW-1:0]           q_im,
    output cau_pkg::cau_div_flags_t flags
);

    // rounded quotient = (|num| * 2^(F+1) + den) / (2 * den)
    logic [NW-1:0]           nq_reg   [0:NW][0:1];
    logic [NW-1:0]           nq_next  [0:NW][0:1];
    logic [32:0]             rem_reg  [0:NW][0:1];
    logic [32:0]             rem_next [0:NW][0:1];
    logic [32:0]             dd_reg   [0:NW];
    logic [32:0]             dd_next  [0:NW];
    cau_pkg::cau_div_flags_t fl_reg   [0:NW];
    cau_pkg::cau_div_flags_t fl_next  [0:NW];

    always_comb
    begin
        logic [32:0] mag_re;
        logic [32:0] mag_im;
        logic [33:0] trial;
        logic        ge;
        mag_re = num_re[32] ? 33'(-num_re) : 33'(num_re);
        mag_im = num_im[32] ? 33'(-num_im) : 33'(num_im);
        nq_next[0][0] = (NW'(mag_re) << (FRAC_BITS + 1)) + NW'(den);
        nq_next[0][1] = (NW'(mag_im) << (FRAC_BITS + 1)) + NW'(den);
        rem_next[0][0] = '0;
        rem_next[0][1] = '0;
        dd_next[0] = {den, 1'b0};
        fl_next[0].zero_den = (den == '0);
        fl_next[0].neg_re   = num_re[32];
        fl_next[0].neg_im   = num_im[32];
        for (int k = 0; k < NW; k++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                trial = {rem_reg[k][l], nq_reg[k][l][NW-1]};
                ge    = (trial >= {1'b0, dd_reg[k]});
                rem_next[k+1][l] = ge ? 33'(trial - {1'b0, dd_reg[k]}) : trial[32:0];
                nq_next[k+1][l]  = {nq_reg[k][l][NW-2:0], ge};
            end
            dd_next[k+1] = dd_reg[k];
            fl_next[k+1] = fl_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        dd_reg  <= dd_next;
        fl_reg  <= fl_next;
    end

    assign q_re  = nq_reg[NW][0];
    assign q_im  = nq_reg[NW][1];
    assign flags = fl_reg[NW];

endmodule

`default_nettype wire

@@ rtl/core/cau_sqrt.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit square root
// Pipelined digit-by-digit square root, rounded to nearest.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_sqrt (
    input  logic        clk,
    input  logic [31:0] sq,
    output logic [15:0] root
);

    localparam int STEPS = 16;

    logic [31:0] s_reg     [0:STEPS];
    logic [31:0] s_next    [0:STEPS];
    logic [17:0] rem_reg   [0:STEPS];
    logic [17:0] rem_next  [0:STEPS];
    logic [15:0] root_reg  [0:STEPS];
    logic [15:0] root_next [0:STEPS];
    logic [15:0] out_reg;

    always_comb
    begin
        logic [19:0] trial;
        logic [19:0] test;
        logic        ge;
        s_next[0]    = sq;
        rem_next[0]  = '0;
        root_next[0] = '0;
        for (int k = 0; k < STEPS; k++)
        begin
            trial = {rem_reg[k], s_reg[k][31:30]};
            test  = {2'b00, root_reg[k], 2'b01};
            ge    = (trial >= test);
            rem_next[k+1]  = ge ? 18'(trial - test) : trial[17:0];
            root_next[k+1] = {root_reg[k][14:0], ge};
            s_next[k+1]    = {s_reg[k][29:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        // remainder is sq - root^2; round up when it exceeds root
        out_reg  <= root_reg[STEPS]
                    + 16'(rem_reg[STEPS] > {2'b00, root_reg[STEPS]});
    end

    assign root = out_reg;

endmodule

`default_nettype wire

@@ rtl/core/cau_cordic.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit CORDIC
// Pipelined vectoring CORDIC giving the angle of a in degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_cordic #(
    parameter int FRAC_BITS    = cau_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = cau_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic signed [15:0] a_re,
    input  logic signed [15:0] a_im,
    output logic signed [31:0] angle
);

    localparam int XW = 36;
    localparam int ZW = 27;
    localparam int RSH = cau_pkg::ANG_FRAC - FRAC_BITS;
    localparam logic signed [ZW-1:0] Z90  = ZW'(90 << cau_pkg::ANG_FRAC);
    localparam logic signed [ZW-1:0] ZRND = ZW'(1 << (RSH - 1));

    logic signed [XW-1:0] x_reg  [0:CORDIC_STEPS];
    logic signed [XW-1:0] x_next [0:CORDIC_STEPS];
    logic signed [XW-1:0] y_reg  [0:CORDIC_STEPS];
    logic signed [XW-1:0] y_next [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg  [0:CORDIC_STEPS];
    logic signed [ZW-1:0] z_next [0:CORDIC_STEPS];
    logic                 zero_reg  [0:CORDIC_STEPS];
    logic                 zero_next [0:CORDIC_STEPS];
    logic signed [31:0]   out_reg;

    always_comb
    begin
        logic signed [XW-1:0] xi;
        logic signed [XW-1:0] yi;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] za;
        xi = XW'(a_re) <<< 16;
        yi = XW'(a_im) <<< 16;
        zero_next[0] = (a_re == '0) && (a_im == '0);
        // left half plane: rotate by 90 degrees first
        if (xi < 0)
        begin
            if (yi >= 0)
            begin
                x_next[0] = yi;
                y_next[0] = -xi;
                z_next[0] = Z90;
            end
            else
            begin
                x_next[0] = -yi;
                y_next[0] = xi;
                z_next[0] = -Z90;
            end
        end
        else
        begin
            x_next[0] = xi;
            y_next[0] = yi;
            z_next[0] = '0;
        end
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            dx = y_reg[k] >>> k;
            dy = x_reg[k] >>> k;
            za = ZW'(cau_pkg::atan_deg(k));
            if (y_reg[k] >= 0)
            begin
                x_next[k+1] = x_reg[k] + dx;
                y_next[k+1] = y_reg[k] - dy;
                z_next[k+1] = z_reg[k] + za;
            end
            else
            begin
                x_next[k+1] = x_reg[k] - dx;
                y_next[k+1] = y_reg[k] + dy;
                z_next[k+1] = z_reg[k] - za;
            end
            zero_next[k+1] = zero_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
        out_reg  <= zero_reg[CORDIC_STEPS] ? '0
                    : 32'((z_reg[CORDIC_STEPS] + ZRND) >>> RSH);
    end

    assign angle = out_reg;

endmodule

`default_nettype wire

@@ rtl/core/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide, conjugate, magnitude and angle of
// complex Q8.8 operands, saturated Q24.8 results.
// ----------------------------------------------------------------------------
//  channel   signals                  handshake
//  item in   operands (cau_in_t)      start high, busy low at clk edge
//  item out  result (cau_out_t)       done high for one cycle
//
//  One item per cycle. Depth is set by the divider: one quotient bit per
//  stage, 34 + FRAC_BITS stages. Magnitude and angle paths are padded to the
//  same depth.
//  Reset clears valid bits only; busy is always low, done is never held.
// ----------------------------------------------------------------------------
`default_nettype none

`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit #(
    parameter int FRAC_BITS    = cau_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = cau_pkg::CORDIC_STEPS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cau_pkg::cau_in_t  operands,
    output logic              done,
    output cau_pkg::cau_out_t result
);

    localparam int NW      = 34 + FRAC_BITS;
    localparam int DL      = 1 + NW;
    localparam int PAD_SQ  = DL - 18;
    localparam int PAD_ANG = DL - CORDIC_STEPS - 2;
    localparam int LAT     = DL + 4;

    localparam logic signed [33:0] S_MAX = 34'sd2147483647;
    localparam logic signed [33:0] S_MIN = -34'sd2147483648;
    localparam logic [NW-1:0] Q_POS_MAX = NW'(32'h7FFF_FFFF);
    localparam logic [NW-1:0] Q_NEG_MAX = NW'(32'h8000_0000);

    typedef struct packed {
        logic [2:0]         op;
        logic signed [33:0] simple_re;
        logic signed [33:0] simple_im;
    } side_t;

    logic                    front_valid;
    cau_pkg::cau_front_t     front_item;
    logic [NW-1:0]           q_re;
    logic [NW-1:0]           q_im;
    cau_pkg::cau_div_flags_t div_flags;
    logic [15:0]             mag_root;
    logic signed [31:0]      angle;

    logic                    valid_reg [0:DL-1];
    side_t                   side_reg  [0:DL-1];
    logic [15:0]             sq_pad_reg  [0:PAD_SQ-1];
    logic signed [31:0]      ang_pad_reg [0:PAD_ANG-1];
    logic                    done_reg;
    cau_pkg::cau_out_t       result_reg, result_next;

    cau_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .in_item   (operands),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    cau_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk    (clk),
        .num_re (front_item.num_re),
        .num_im (front_item.num_im),
        .den    (front_item.den),
        .q_re   (q_re),
        .q_im   (q_im),
        .flags  (div_flags)
    );

    cau_sqrt u_sqrt (
        .clk  (clk),
        .sq   (front_item.mag_sq),
        .root (mag_root)
    );

    cau_cordic #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .a_re  (front_item.a_re),
        .a_im  (front_item.a_im),
        .angle (angle)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DL; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= front_valid;
            for (int i = 1; i < DL; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
            done_reg <= valid_reg[DL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0].op        <= front_item.op;
        side_reg[0].simple_re <= front_item.simple_re;
        side_reg[0].simple_im <= front_item.simple_im;
        for (int i = 1; i < DL; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
        sq_pad_reg[0] <= mag_root;
        for (int i = 1; i < PAD_SQ; i++)
        begin
            sq_pad_reg[i] <= sq_pad_reg[i-1];
        end
        ang_pad_reg[0] <= angle;
        for (int i = 1; i < PAD_ANG; i++)
        begin
            ang_pad_reg[i] <= ang_pad_reg[i-1];
        end
        result_reg <= result_next;
    end

    always_comb
    begin
        side_t s;
        logic  clip_re;
        logic  clip_im;
        s = side_reg[DL-1];
        clip_re = div_flags.neg_re ? (q_re > Q_NEG_MAX) : (q_re > Q_POS_MAX);
        clip_im = div_flags.neg_im ? (q_im > Q_NEG_MAX) : (q_im > Q_POS_MAX);
        result_next = '0;
        case (s.op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL, cau_pkg::OP_CONJ:
            begin
                if (s.simple_re > S_MAX)
                begin
                    result_next.res_re    = 32'h7FFF_FFFF;
                    result_next.saturated = 1'b1;
                end
                else if (s.simple_re < S_MIN)
                begin
                    result_next.res_re    = 32'h8000_0000;
                    result_next.saturated = 1'b1;
                end
                else
                begin
                    result_next.res_re = 32'(s.simple_re);
                end
                if (s.simple_im > S_MAX)
                begin
                    result_next.res_im    = 32'h7FFF_FFFF;
                    result_next.saturated = 1'b1;
                end
                else if (s.simple_im < S_MIN)
                begin
                    result_next.res_im    = 32'h8000_0000;
                    result_next.saturated = 1'b1;
                end
                else
                begin
                    result_next.res_im = 32'(s.simple_im);
                end
            end
            cau_pkg::OP_DIV:
            begin
                if (div_flags.zero_den)
                begin
                    result_next.invalid = 1'b1;
                end
                else
                begin
                    if (clip_re)
                    begin
                        result_next.res_re = div_flags.neg_re ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    end
                    else
                    begin
                        result_next.res_re = div_flags.neg_re ? -q_re[31:0] : q_re[31:0];
                    end
                    if (clip_im)
                    begin
                        result_next.res_im = div_flags.neg_im ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    end
                    else
                    begin
                        result_next.res_im = div_flags.neg_im ? -q_im[31:0] : q_im[31:0];
                    end
                    result_next.saturated = clip_re || clip_im;
                end
            end
            cau_pkg::OP_MAG:
            begin
                result_next.res_re = {16'd0, sq_pad_reg[PAD_SQ-1]};
            end
            cau_pkg::OP_ANGLE:
            begin
                result_next.res_re = ang_pad_reg[PAD_ANG-1];
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    `CAU_ASSERT_DELAY(a_latency, start && !busy, (LAT), done, "item result missing at fixed latency")
    `CAU_ASSERT_IMPLY(a_no_phantom, done, $past(start && !busy, LAT), "result without an item")
    `CAU_ASSERT_IMPLY(a_invalid_zero, done && result.invalid,
        result.res_re == '0 && result.res_im == '0 && !result.saturated,
        "invalid divide result not cleared")

endmodule

`default_nettype wire

@@ tb/complex_arithmetic_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Directed and random operand items for every opcode; each result is checked
// field by field against a predictor of the fixed point math, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;

    localparam int FRAC = 8;
    localparam int STEPS = 16;
    localparam int LATENCY = FRAC + 39;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [2:0] OP_UNUSED = 3'd7;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    cau_pkg::cau_in_t  operands;
    logic              done;
    cau_pkg::cau_out_t result;

    cau_pkg::cau_in_t  pending_items[$];
    cau_pkg::cau_out_t expected_results[$];
    int                error_count;
    int                idle_cycles;
    int                gap_left;
    bit                stimulus_done;

    complex_arithmetic_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operands(operands),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        if (s == 0)
            return v;
        return floor_shift(v + (longint'(1) << (s - 1)), s);
    endfunction

    function automatic longint div_nearest(longint num, longint den);
        longint n;
        longint q;
        n = (num < 0 ? -num : num) <<< (FRAC + 1);
        q = (n + den) / (2 * den);
        return num < 0 ? -q : q;
    endfunction

    function automatic longint sqrt_nearest(longint s);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= s)
            r = r + ((s - (r + 1) * (r + 1)) > 4 * r + 1000 ? (r + 1) : 1);
        // coarse search above can overshoot in steps; settle exactly
        while (r * r > s)
            r--;
        if (s - r * r > r)
            r++;
        return r;
    endfunction

    function automatic longint atan_entry(int i);
        longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                            58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                            229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
        return tab[i];
    endfunction

    function automatic longint angle_degrees(longint re, longint im);
        longint x;
        longint y;
        longint z;
        longint t;
        longint dx;
        longint dy;
        x = re * 65536;
        y = im * 65536;
        z = 0;
        if (re == 0 && im == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = longint'(90) << cau_pkg::ANG_FRAC;
            end
            else
            begin
                x = -y;
                y = t;
                z = -(longint'(90) << cau_pkg::ANG_FRAC);
            end
        end
        for (int i = 0; i < (STEPS > 24 ? 24 : STEPS); i++)
        begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += atan_entry(i);
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= atan_entry(i);
            end
        end
        return round_shift(z, cau_pkg::ANG_FRAC - FRAC);
    endfunction

    function automatic longint clip32(longint v, ref bit sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic cau_pkg::cau_out_t complex_result(cau_pkg::cau_in_t it);
        cau_pkg::cau_out_t r;
        longint ar;
        longint ai;
        longint br;
        longint bi;
        longint re;
        longint im;
        longint den;
        bit inv;
        bit sat;
        ar = it.a_re;
        ai = it.a_im;
        br = it.b_re;
        bi = it.b_im;
        re = 0;
        im = 0;
        inv = 1'b0;
        sat = 1'b0;
        case (it.op)
            cau_pkg::OP_ADD:
            begin
                re = ar + br;
                im = ai + bi;
            end
            cau_pkg::OP_SUB:
            begin
                re = ar - br;
                im = ai - bi;
            end
            cau_pkg::OP_MUL:
            begin
                re = round_shift(ar * br - ai * bi, FRAC);
                im = round_shift(ar * bi + ai * br, FRAC);
            end
            cau_pkg::OP_DIV:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    inv = 1'b1;
                else
                begin
                    re = div_nearest(ar * br + ai * bi, den);
                    im = div_nearest(ai * br - ar * bi, den);
                end
            end
            cau_pkg::OP_CONJ:
            begin
                re = ar;
                im = -ai;
            end
            cau_pkg::OP_MAG:   re = sqrt_nearest(ar * ar + ai * ai);
            cau_pkg::OP_ANGLE: re = angle_degrees(ar, ai);
            default:  ;
        endcase
        re = clip32(re, sat);
        im = clip32(im, sat);
        r.res_re = re[31:0];
        r.res_im = im[31:0];
        r.invalid = inv;
        r.saturated = sat;
        return r;
    endfunction

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'(int'($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_item(logic [2:0] op, logic [15:0] ar, logic [15:0] ai,
                            logic [15:0] br, logic [15:0] bi);
        cau_pkg::cau_in_t it;
        it.op = op;
        it.a_re = ar;
        it.a_im = ai;
        it.b_re = br;
        it.b_im = bi;
        pending_items.push_back(it);
    endtask

    initial
    begin
        logic [2:0] op;
        rst_n = 1'b0;
        stimulus_done = 1'b0;
        for (int k = 0; k <= 7; k++)
            add_item(3'(k), 16'h0300, 16'hFE80, 16'h0100, 16'h0240);
        add_item(cau_pkg::OP_ADD, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        add_item(cau_pkg::OP_SUB, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        add_item(cau_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        add_item(cau_pkg::OP_MUL, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
        add_item(cau_pkg::OP_DIV, 16'h1234, 16'h5678, 16'h0000, 16'h0000);
        add_item(cau_pkg::OP_DIV, 16'h7FFF, 16'h8000, 16'h0001, 16'h0000);
        add_item(cau_pkg::OP_DIV, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF);
        add_item(cau_pkg::OP_CONJ, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
        add_item(cau_pkg::OP_MAG, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF);
        add_item(cau_pkg::OP_MAG, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
        add_item(cau_pkg::OP_ANGLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_item(cau_pkg::OP_ANGLE, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
        add_item(cau_pkg::OP_ANGLE, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000);
        add_item(cau_pkg::OP_ANGLE, 16'h0000, 16'h8000, 16'h0000, 16'h0000);
        add_item(cau_pkg::OP_ANGLE, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000);
        for (int n = 0; n < 1700; n++)
        begin
            op = ($urandom_range(0, 40) == 0) ? OP_UNUSED : 3'($urandom_range(0, 6));
            add_item(op, pick_operand(), pick_operand(), pick_operand(),
                     pick_operand());
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        stimulus_done = 1'b1;
    end

    // driver: gaps drawn per item, zero gap keeps start high back to back
    always @(posedge clk or negedge rst_n)
    begin
        int gap;
        if (!rst_n)
        begin
            start <= 1'b0;
            operands <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.push_back(complex_result(operands));
                gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 19));
                if (gap == 0 && pending_items.size() != 0)
                begin
                    operands <= pending_items.pop_front();
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                    gap_left <= (gap == 0) ? 0 : gap - 1;
                end
            end
            else if (!start)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (pending_items.size() != 0)
                begin
                    operands <= pending_items.pop_front();
                    start <= 1'b1;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        cau_pkg::cau_out_t exp_r;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no item outstanding");
                    error_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (result.res_re !== exp_r.res_re)
                    begin
                        $error("res_re expected %0d actual %0d", exp_r.res_re, result.res_re);
                        error_count++;
                    end
                    if (result.res_im !== exp_r.res_im)
                    begin
                        $error("res_im expected %0d actual %0d", exp_r.res_im, result.res_im);
                        error_count++;
                    end
                    if (result.invalid !== exp_r.invalid)
                    begin
                        $error("invalid expected %0b actual %0b", exp_r.invalid, result.invalid);
                        error_count++;
                    end
                    if (result.saturated !== exp_r.saturated)
                    begin
                        $error("saturated expected %0b actual %0b", exp_r.saturated,
                               result.saturated);
                        error_count++;
                    end
                end
            end
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        wait (stimulus_done);
        while (!(pending_items.size() == 0 && !start && expected_results.size() == 0)
               && idle_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            repeat (LATENCY + 10) @(posedge clk);
            if (error_count == 0 && expected_results.size() == 0)
                $display("All tests passed");
            else
                $display("Some tests failed");
            $finish;
        end
    end
endmodule
